[design/mpoly_pkg.sv]
`timescale 1ns / 1ps
package mpoly_pkg;
   localparam int DIM_DEFAULT       = 3;
   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int VALUE_W           = 16;
   localparam int IDX_W             = 2;
   localparam int RESULT_W          = 51;
   localparam int SQ_W              = 34;

   localparam logic [1:0] KIND_LOAD_A  = 2'd0;
   localparam logic [1:0] KIND_LOAD_B  = 2'd1;
   localparam logic [1:0] KIND_COMPUTE = 2'd2;

   // Control handed from the sequencer to the cell row each cycle.
   typedef struct packed {
      logic shift;   // rotate the row so the next element reaches the head
   } cell_ctrl_type;
endpackage

[design/mpoly_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the matrix row: holds one element of A, of B and of
// A squared, and passes them to its neighbor when the row rotates.
module mpoly_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mpoly_pkg::cell_ctrl_type              ctrl,
   input  logic                                  load_a,
   input  logic                                  load_b,
   input  logic                                  load_sq,
   input  logic signed [mpoly_pkg::VALUE_W-1:0]  value,
   input  logic signed [mpoly_pkg::SQ_W-1:0]     sq_value,
   input  logic signed [mpoly_pkg::VALUE_W-1:0]  a_prev,
   input  logic signed [mpoly_pkg::VALUE_W-1:0]  b_prev,
   input  logic signed [mpoly_pkg::SQ_W-1:0]     sq_prev,
   output logic signed [mpoly_pkg::VALUE_W-1:0]  a_out,
   output logic signed [mpoly_pkg::VALUE_W-1:0]  b_out,
   output logic signed [mpoly_pkg::SQ_W-1:0]     sq_out
);
   logic signed [mpoly_pkg::VALUE_W-1:0] a_ff, b_ff;
   logic signed [mpoly_pkg::SQ_W-1:0]    sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
      end else if (ctrl.shift) begin
         a_ff <= a_prev;
         b_ff <= b_prev;
      end else begin
         if (load_a) a_ff <= value;
         if (load_b) b_ff <= value;
      end
   end

   // A squared is written while the row rotates, so the write wins.
   always_ff @(posedge clock) begin
      if (load_sq) sq_ff <= sq_value;
      else if (ctrl.shift) sq_ff <= sq_prev;
   end

   assign a_out  = a_ff;
   assign b_out  = b_ff;
   assign sq_out = sq_ff;
endmodule

[design/matrix_poly_a2b_plus_2b_minus_a_core.sv]
`timescale 1ns / 1ps
// Matrix polynomial core: C = A*A*B + 2*B - A over DIM x DIM signed Q8.8
// matrices.
// Requests arrive on the req_ channel. A load request (kind 0 for A, kind 1
// for B) writes one element at row/col and gives no response; loads can
// follow back to back. Out-of-range indices and kind 3 are dropped. A
// compute request (kind 2) first forms A squared, then streams DIM*DIM
// elements of C on the rsp_ channel in row-major order, the last one
// flagged by rsp_last.
// Elements live in a ring of DIM*DIM cells that rotates by one place every
// cycle while a compute runs; one shared multiplier at the head of the ring
// does all products. Each product waits for each of its two operands to
// reach the head, then multiplies and adds, so the ring rotation sets the
// rate. After the last result the ring turns home before the next request
// is taken. Reset clears both matrices, homes the ring and returns the
// sequencer to idle. When the receiver stalls, the result register holds
// and the sequencer waits; no request is taken until then.
module matrix_poly_a2b_plus_2b_minus_a_core #(
   parameter int DIM       = mpoly_pkg::DIM_DEFAULT,
   parameter int FRAC_BITS = mpoly_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_kind,
   input  logic [mpoly_pkg::IDX_W-1:0]           req_row,
   input  logic [mpoly_pkg::IDX_W-1:0]           req_col,
   input  logic signed [mpoly_pkg::VALUE_W-1:0]  req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mpoly_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [mpoly_pkg::IDX_W-1:0]           rsp_out_col,
   output logic signed [mpoly_pkg::RESULT_W-1:0] rsp_result,
   output logic                                  rsp_last
);
   localparam int N    = DIM * DIM;
   localparam int PW   = (N > 1) ? $clog2(N) : 1;
   localparam int KW   = $clog2(DIM + 1);
   localparam int VW   = mpoly_pkg::VALUE_W;
   localparam int SW   = mpoly_pkg::SQ_W;
   localparam int RW   = mpoly_pkg::RESULT_W;
   localparam int PRW  = SW + VW;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQ_FETCH, ST_SQ_MAC, ST_C_FETCH, ST_C_MAC, ST_EMIT
   } state_type;

   state_type state_ff;
   // Ring position: the element whose flat index equals rot_ff sits at the head.
   logic [PW-1:0] rot_ff;
   logic [PW-1:0] i_ff, j_ff;       // current output row, column
   logic [KW-1:0] k_ff;             // term index
   logic          ph_ff;            // 0: fetch first operand, 1: second
   logic [PW-1:0] tgt_ff;           // flat index being fetched
   logic signed [SW-1:0] opa_ff;    // latched first operand
   logic signed [PRW-1:0] prod_ff;
   logic          prod_v_ff;
   logic signed [RW-1:0] acc_ff;
   logic [PW-1:0] oi_ff;            // flat index of the element being formed

   logic signed [VW-1:0] a_q [N];
   logic signed [VW-1:0] b_q [N];
   logic signed [SW-1:0] s_q [N];
   mpoly_pkg::cell_ctrl_type ctrl;
   logic load_ok;
   logic [PW-1:0] load_idx;
   logic sq_wr;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid && (rot_ff == '0);
   assign load_ok = (32'(req_row) < DIM) && (32'(req_col) < DIM);
   assign load_idx = PW'(32'(req_row) * DIM + 32'(req_col));
   // The ring turns during a compute and, once idle, until it is home again.
   assign ctrl.shift = (state_ff != ST_IDLE) || (rot_ff != '0);

   // Cell 0 is the head; data moves from cell m+1 to cell m, wrapping.
   for (genvar m = 0; m < N; m++) begin : g_cell
      localparam int NX = (m + 1) % N;
      logic wa, wb, ws;
      assign wa = req_valid && req_ready && load_ok
                  && req_kind == mpoly_pkg::KIND_LOAD_A && load_idx == PW'(m);
      assign wb = req_valid && req_ready && load_ok
                  && req_kind == mpoly_pkg::KIND_LOAD_B && load_idx == PW'(m);
      assign ws = sq_wr && m == N - 1;
      mpoly_cell u_cell (
         .clock, .reset, .ctrl,
         .load_a(wa), .load_b(wb), .load_sq(ws),
         .value(req_value), .sq_value(SW'(acc_ff)),
         .a_prev(a_q[NX]), .b_prev(b_q[NX]), .sq_prev(s_q[NX]),
         .a_out(a_q[m]), .b_out(b_q[m]), .sq_out(s_q[m])
      );
   end

   // Loads only happen while the ring is at home, so cell index = flat index.
   // A squared is written into the tail cell at the cycle the ring holds
   // its element's position there: tail_idx tracks that position.
   logic [PW-1:0] rot_next;
   assign rot_next = (rot_ff == PW'(N - 1)) ? '0 : rot_ff + 1'b1;
   logic at_tgt;
   assign at_tgt = (rot_ff == tgt_ff);
   // The tail cell holds flat index rot_ff after this edge's shift.
   logic [PW-1:0] tail_idx;
   assign tail_idx = rot_ff;
   assign sq_wr = (state_ff == ST_SQ_MAC) && !prod_v_ff && (k_ff == KW'(DIM))
                  && (tail_idx == oi_ff);

   logic signed [SW-1:0] head_a, head_s;
   assign head_a = SW'(a_q[0]);
   assign head_s = s_q[0];

   logic [PW-1:0] flat_ik, flat_kj;
   assign flat_ik = PW'(32'(i_ff) * DIM + 32'(k_ff));
   assign flat_kj = PW'(32'(k_ff) * DIM + 32'(j_ff));

   logic signed [RW-1:0] fix_term;
   assign fix_term = (RW'(signed'(b_q[0])) <<< (2 * FRAC_BITS + 1))
                   - (RW'(signed'(a_q[0])) <<< (2 * FRAC_BITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rot_ff    <= '0;
         rsp_valid <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         if (ctrl.shift) rot_ff <= rot_next;
         prod_v_ff <= 1'b0;
         if (prod_v_ff) acc_ff <= acc_ff + RW'(prod_ff);
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready && req_kind == mpoly_pkg::KIND_COMPUTE) begin
                  state_ff <= ST_SQ_FETCH;
                  i_ff <= '0; j_ff <= '0; k_ff <= '0; ph_ff <= 1'b0;
                  oi_ff <= '0; acc_ff <= '0;
                  tgt_ff <= '0;
               end
            end
            ST_SQ_FETCH: begin
               // Wait until the wanted element of A is at the head.
               if (at_tgt) begin
                  if (!ph_ff) begin
                     opa_ff <= head_a;
                     ph_ff  <= 1'b1;
                     tgt_ff <= PW'(32'(k_ff) * DIM + 32'(j_ff));
                  end else begin
                     prod_ff   <= opa_ff * a_q[0];
                     prod_v_ff <= 1'b1;
                     ph_ff     <= 1'b0;
                     k_ff      <= k_ff + 1'b1;
                     state_ff  <= ST_SQ_MAC;
                  end
               end
            end
            ST_SQ_MAC: begin
               if (!prod_v_ff) begin
                  if (k_ff != KW'(DIM)) begin
                     tgt_ff   <= flat_ik;
                     state_ff <= ST_SQ_FETCH;
                  end else if (sq_wr) begin
                     acc_ff <= '0;
                     k_ff   <= '0;
                     if (j_ff == PW'(DIM - 1)) begin
                        j_ff <= '0;
                        if (i_ff == PW'(DIM - 1)) begin
                           i_ff <= '0;
                           oi_ff <= '0;
                           tgt_ff <= '0;
                           state_ff <= ST_C_FETCH;
                        end else begin
                           i_ff <= i_ff + 1'b1;
                           oi_ff <= oi_ff + 1'b1;
                           tgt_ff <= PW'(32'(i_ff + 1'b1) * DIM);
                           state_ff <= ST_SQ_FETCH;
                        end
                     end else begin
                        j_ff <= j_ff + 1'b1;
                        oi_ff <= oi_ff + 1'b1;
                        tgt_ff <= PW'(32'(i_ff) * DIM);
                        state_ff <= ST_SQ_FETCH;
                     end
                  end
               end
            end
            ST_C_FETCH: begin
               if (at_tgt) begin
                  if (!ph_ff) begin
                     opa_ff <= head_s;
                     ph_ff  <= 1'b1;
                     tgt_ff <= flat_kj;
                  end else begin
                     prod_ff   <= opa_ff * b_q[0];
                     prod_v_ff <= 1'b1;
                     ph_ff     <= 1'b0;
                     k_ff      <= k_ff + 1'b1;
                     state_ff  <= ST_C_MAC;
                  end
               end
            end
            ST_C_MAC: begin
               if (!prod_v_ff) begin
                  if (k_ff != KW'(DIM)) begin
                     tgt_ff   <= flat_ik;
                     state_ff <= ST_C_FETCH;
                  end else begin
                     tgt_ff   <= oi_ff;
                     state_ff <= ST_EMIT;
                     ph_ff    <= 1'b1;
                  end
               end
            end
            default: begin // ST_EMIT
               if (ph_ff) begin
                  // The ring keeps turning; the linear term is added when the
                  // element being formed is at the head.
                  if (rot_ff == oi_ff) begin
                     rsp_valid   <= 1'b1;
                     rsp_out_row <= mpoly_pkg::IDX_W'(i_ff);
                     rsp_out_col <= mpoly_pkg::IDX_W'(j_ff);
                     rsp_result  <= acc_ff + fix_term;
                     rsp_last    <= (oi_ff == PW'(N - 1));
                     ph_ff       <= 1'b0;
                  end
               end else if (rsp_valid && rsp_ready) begin
                  rsp_valid <= 1'b0;
                  acc_ff <= '0;
                  k_ff   <= '0;
                  if (oi_ff == PW'(N - 1)) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     oi_ff <= oi_ff + 1'b1;
                     if (j_ff == PW'(DIM - 1)) begin
                        j_ff <= '0;
                        i_ff <= i_ff + 1'b1;
                        tgt_ff <= PW'(32'(i_ff + 1'b1) * DIM);
                     end else begin
                        j_ff <= j_ff + 1'b1;
                        tgt_ff <= PW'(32'(i_ff) * DIM);
                     end
                     state_ff <= ST_C_FETCH;
                  end
               end
            end
         endcase
      end
   end

   // The ring must be at its home position whenever requests are taken.
   a_home: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> rot_ff == '0)
      else $error("ring not at home while taking a request");
   // No response is raised outside the emit phase.
   a_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_EMIT)
      else $error("response raised outside emit");
   // A held response keeps its data while stalled.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result) && rsp_valid)
      else $error("stalled response changed");
endmodule
